/* rtl/hsvg_pkg.sv */
// ----------------------------------------------------------------------------
// hsvg_pkg
// Types, register codes and reset values shared by the gradient pipeline.
// ----------------------------------------------------------------------------
package hsvg_pkg;

    localparam int LANES    = 3;
    localparam int LANE_HUE = 0;
    localparam int LANE_SAT = 1;
    localparam int LANE_VAL = 2;

    localparam int CFG_INDEX_W = 3;

    localparam logic signed [9:0] HUE_HALF   = 10'sd127;
    localparam logic signed [9:0] HUE_CIRCLE = 10'sd256;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BASE_HUE   = 3'd0,
        REG_BASE_SAT   = 3'd1,
        REG_BASE_VAL   = 3'd2,
        REG_ACCENT_HUE = 3'd3,
        REG_ACCENT_SAT = 3'd4,
        REG_ACCENT_VAL = 3'd5,
        REG_SPAN_Y     = 3'd6
    } cfg_index_t;

    localparam logic [7:0] RST_BASE_HUE   = 8'd190;
    localparam logic [7:0] RST_BASE_SAT   = 8'd176;
    localparam logic [7:0] RST_BASE_VAL   = 8'd189;
    localparam logic [7:0] RST_ACCENT_HUE = 8'd133;
    localparam logic [7:0] RST_ACCENT_SAT = 8'd223;
    localparam logic [7:0] RST_ACCENT_VAL = 8'd228;
    localparam logic [7:0] RST_SPAN_Y     = 8'd1;

    typedef struct packed {
        logic [7:0] led_y;
        logic [7:0] map_hue;
        logic [7:0] map_sat;
        logic [7:0] map_val;
    } item_t;

    typedef struct packed {
        logic [7:0] out_hue;
        logic [7:0] out_sat;
        logic [7:0] out_val;
    } result_t;

    typedef struct packed {
        logic [7:0] base_hue;
        logic [7:0] base_sat;
        logic [7:0] base_val;
        logic [7:0] accent_hue;
        logic [7:0] accent_sat;
        logic [7:0] accent_val;
        logic [7:0] span_y;
    } cfg_t;

    // Per-LED word carried down the divider stages.
    typedef struct packed {
        logic                   pass;
        logic [7:0]             map_hue;
        logic [7:0]             map_sat;
        logic [7:0]             map_val;
        logic [LANES-1:0]       neg;
        logic [LANES-1:0][15:0] rem;
        logic [LANES-1:0][7:0]  quot;
    } pkt_t;

endpackage

/* rtl/hsvg_front.sv */
// ----------------------------------------------------------------------------
// hsvg_front
// Clamp y, form the signed deltas and multiply each magnitude by y.
// ----------------------------------------------------------------------------
module hsvg_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  hsvg_pkg::cfg_t cfg,
    input  logic [7:0]     span,
    input  logic           up_valid,
    output logic           up_ready,
    input  hsvg_pkg::item_t up_data,
    output logic           dn_valid,
    input  logic           dn_ready,
    output hsvg_pkg::pkt_t dn_data
);

    logic           valid_reg;
    hsvg_pkg::pkt_t data_reg;
    hsvg_pkg::pkt_t data_next;

    always_comb
    begin
        logic [hsvg_pkg::LANES-1:0][7:0] base;
        logic [hsvg_pkg::LANES-1:0][7:0] accent;
        logic signed [9:0]               diff;
        logic signed [9:0]               mag_w;
        logic [7:0]                      y_c;

        base[hsvg_pkg::LANE_HUE]   = cfg.base_hue;
        base[hsvg_pkg::LANE_SAT]   = cfg.base_sat;
        base[hsvg_pkg::LANE_VAL]   = cfg.base_val;
        accent[hsvg_pkg::LANE_HUE] = cfg.accent_hue;
        accent[hsvg_pkg::LANE_SAT] = cfg.accent_sat;
        accent[hsvg_pkg::LANE_VAL] = cfg.accent_val;

        y_c = (up_data.led_y > span) ? span : up_data.led_y;

        data_next.pass    = (up_data.map_hue != 8'd0) || (up_data.map_sat != 8'd0)
                            || (up_data.map_val != 8'd0);
        data_next.map_hue = up_data.map_hue;
        data_next.map_sat = up_data.map_sat;
        data_next.map_val = up_data.map_val;

        for (int l = 0; l < hsvg_pkg::LANES; l++)
        begin
            diff = signed'({2'b00, accent[l]}) - signed'({2'b00, base[l]});
            // hue goes the short way round the circle
            if (l == hsvg_pkg::LANE_HUE)
            begin
                if (diff > hsvg_pkg::HUE_HALF)
                    diff = diff - hsvg_pkg::HUE_CIRCLE;
                else if (diff < -hsvg_pkg::HUE_HALF)
                    diff = diff + hsvg_pkg::HUE_CIRCLE;
            end
            mag_w             = diff[9] ? -diff : diff;
            data_next.neg[l]  = diff[9];
            data_next.rem[l]  = 16'(mag_w[7:0]) * 16'(y_c);
            data_next.quot[l] = 8'd0;
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

/* rtl/hsvg_div_stage.sv */
// ----------------------------------------------------------------------------
// hsvg_div_stage
// Two restoring division steps per lane, quotient bits HI_BIT and HI_BIT-1.
// ----------------------------------------------------------------------------
module hsvg_div_stage
#(
    parameter int HI_BIT = 7
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic [7:0]     span,
    input  logic           up_valid,
    output logic           up_ready,
    input  hsvg_pkg::pkt_t up_data,
    output logic           dn_valid,
    input  logic           dn_ready,
    output hsvg_pkg::pkt_t dn_data
);

    localparam int LO_BIT = HI_BIT - 1;

    logic           valid_reg;
    hsvg_pkg::pkt_t data_reg;
    hsvg_pkg::pkt_t data_next;
    logic [15:0]    div_hi;
    logic [15:0]    div_lo;
    logic [15:0]    rem_bound;
    logic [7:0]     low_mask;

    assign div_hi    = 16'(span) << HI_BIT;
    assign div_lo    = 16'(span) << LO_BIT;
    assign rem_bound = div_lo;
    assign low_mask  = 8'((9'd1 << LO_BIT) - 9'd1);

    always_comb
    begin
        logic [15:0] r;

        data_next = up_data;
        for (int l = 0; l < hsvg_pkg::LANES; l++)
        begin
            r = up_data.rem[l];
            if (r >= div_hi)
            begin
                r                 = r - div_hi;
                data_next.quot[l] = data_next.quot[l] | (8'd1 << HI_BIT);
            end
            if (r >= div_lo)
            begin
                r                 = r - div_lo;
                data_next.quot[l] = data_next.quot[l] | (8'd1 << LO_BIT);
            end
            data_next.rem[l] = r;
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    // remainder must be below this stage's low divisor step (span << LO_BIT) on every gradient lane
    a_rem_bound : assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !data_reg.pass |->
            (data_reg.rem[0] < rem_bound) && (data_reg.rem[1] < rem_bound)
            && (data_reg.rem[2] < rem_bound))
        else $error("divider remainder out of range");

    // lower quotient bits stay clear until their stage
    a_quot_low : assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |->
            ((data_reg.quot[0] & low_mask) == 8'd0)
            && ((data_reg.quot[1] & low_mask) == 8'd0)
            && ((data_reg.quot[2] & low_mask) == 8'd0))
        else $error("quotient bit set ahead of its stage");

endmodule

/* rtl/hsvg_back.sv */
// ----------------------------------------------------------------------------
// hsvg_back
// Apply the sign, add the base color, pick the map color when it is set.
// ----------------------------------------------------------------------------
module hsvg_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  hsvg_pkg::cfg_t    cfg,
    input  logic              up_valid,
    output logic              up_ready,
    input  hsvg_pkg::pkt_t    up_data,
    output logic              dn_valid,
    input  logic              dn_ready,
    output hsvg_pkg::result_t dn_data
);

    logic              valid_reg;
    hsvg_pkg::result_t data_reg;
    hsvg_pkg::result_t data_next;

    always_comb
    begin
        logic [hsvg_pkg::LANES-1:0][7:0] base;
        logic [hsvg_pkg::LANES-1:0][7:0] mixed;
        logic [7:0]                      q;

        base[hsvg_pkg::LANE_HUE] = cfg.base_hue;
        base[hsvg_pkg::LANE_SAT] = cfg.base_sat;
        base[hsvg_pkg::LANE_VAL] = cfg.base_val;

        // modulo 256 falls out of the 8-bit add
        for (int l = 0; l < hsvg_pkg::LANES; l++)
        begin
            q        = up_data.quot[l];
            mixed[l] = up_data.neg[l] ? (base[l] - q) : (base[l] + q);
        end

        if (up_data.pass)
        begin
            data_next.out_hue = up_data.map_hue;
            data_next.out_sat = up_data.map_sat;
            data_next.out_val = up_data.map_val;
        end
        else
        begin
            data_next.out_hue = mixed[hsvg_pkg::LANE_HUE];
            data_next.out_sat = mixed[hsvg_pkg::LANE_SAT];
            data_next.out_val = mixed[hsvg_pkg::LANE_VAL];
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

/* rtl/hsv_vertical_gradient_led_unit.sv */
// Pipeline: front, four divider stages and output stage, each one registered;
// one request per cycle sustained while the output is not stalled.
// The rate is set by the divider, which resolves two quotient bits per stage
// in three lanes side by side; each stage holds its word while stalled.
// Reset clears all stage valid bits and loads the default gradient colors.
// ----------------------------------------------------------------------------
// hsv_vertical_gradient_led_unit
// Per-LED vertical HSV gradient with fixed-color override from the layer map.
// ----------------------------------------------------------------------------
module hsv_vertical_gradient_led_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [hsvg_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [7:0]                          cfg_data,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  hsvg_pkg::item_t                     item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output hsvg_pkg::result_t                   result
);

    localparam int DIV_STAGES = 4;

    hsvg_pkg::cfg_t cfg_reg;
    logic [7:0]     span;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_hue   <= hsvg_pkg::RST_BASE_HUE;
            cfg_reg.base_sat   <= hsvg_pkg::RST_BASE_SAT;
            cfg_reg.base_val   <= hsvg_pkg::RST_BASE_VAL;
            cfg_reg.accent_hue <= hsvg_pkg::RST_ACCENT_HUE;
            cfg_reg.accent_sat <= hsvg_pkg::RST_ACCENT_SAT;
            cfg_reg.accent_val <= hsvg_pkg::RST_ACCENT_VAL;
            cfg_reg.span_y     <= hsvg_pkg::RST_SPAN_Y;
        end
        else if (cfg_we)
        begin
            case (hsvg_pkg::cfg_index_t'(cfg_index))
                hsvg_pkg::REG_BASE_HUE:   cfg_reg.base_hue   <= cfg_data;
                hsvg_pkg::REG_BASE_SAT:   cfg_reg.base_sat   <= cfg_data;
                hsvg_pkg::REG_BASE_VAL:   cfg_reg.base_val   <= cfg_data;
                hsvg_pkg::REG_ACCENT_HUE: cfg_reg.accent_hue <= cfg_data;
                hsvg_pkg::REG_ACCENT_SAT: cfg_reg.accent_sat <= cfg_data;
                hsvg_pkg::REG_ACCENT_VAL: cfg_reg.accent_val <= cfg_data;
                hsvg_pkg::REG_SPAN_Y:     cfg_reg.span_y     <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // zero span acts as one
    assign span = (cfg_reg.span_y == 8'd0) ? 8'd1 : cfg_reg.span_y;

    logic           st_valid [DIV_STAGES+1];
    logic           st_ready [DIV_STAGES+1];
    hsvg_pkg::pkt_t st_data  [DIV_STAGES+1];

    hsvg_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .span     (span),
        .up_valid (item_valid),
        .up_ready (item_ready),
        .up_data  (item),
        .dn_valid (st_valid[0]),
        .dn_ready (st_ready[0]),
        .dn_data  (st_data[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        hsvg_div_stage
        #(
            .HI_BIT (7 - 2 * g)
        )
        u_div
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .span     (span),
            .up_valid (st_valid[g]),
            .up_ready (st_ready[g]),
            .up_data  (st_data[g]),
            .dn_valid (st_valid[g+1]),
            .dn_ready (st_ready[g+1]),
            .dn_data  (st_data[g+1])
        );
    end

    hsvg_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .up_valid (st_valid[DIV_STAGES]),
        .up_ready (st_ready[DIV_STAGES]),
        .up_data  (st_data[DIV_STAGES]),
        .dn_valid (result_valid),
        .dn_ready (result_ready),
        .dn_data  (result)
    );

    // input backs up only when a result waits at the output
    a_ready_stall : assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> result_valid && !result_ready)
        else $error("input stalled with the output free");

endmodule
